// File: design/ste_pkg.sv
// Shared types and constants for the sextet text encoder.
package ste_pkg;

  localparam logic [6:0] CHAR_BIAS = 7'd33;
  localparam logic [6:0] CHAR_CR   = 7'd13;
  localparam logic [6:0] CHAR_LF   = 7'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } ste_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_end;
    logic       message_end;
  } ste_out_t;

  // One assembled group, ready to be sent out character by character.
  typedef struct packed {
    logic [3:0][5:0] piece;
    logic [1:0]      last_idx;
    logic            brk;
    logic [1:0]      brk_pos;
    logic            last;
  } ste_job_t;

  typedef enum logic [1:0] {
    SEQ_CHAR,
    SEQ_CR,
    SEQ_LF
  } ste_seq_t;

endpackage

// File: design/ste_emit.sv
// Output sequencer: sends the characters of one group plus an optional CR LF.
module ste_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ste_pkg::ste_job_t job,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output ste_pkg::ste_out_t out_data
);
  import ste_pkg::*;

  ste_job_t   job_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  ste_seq_t   st_r, st_nxt;
  logic       at_brk, end_char, run_end, fire;

  assign at_brk   = job_r.brk && (idx_r == job_r.brk_pos);
  assign end_char = (idx_r == job_r.last_idx) && !at_brk;
  assign fire     = busy_r && out_ready;
  assign out_valid = busy_r;
  assign free     = !busy_r || (out_ready && run_end);

  always_comb begin
    run_end = 1'b0;
    out_data.out_char = CHAR_BIAS;
    case (st_r)
      SEQ_CHAR: begin
        out_data.out_char = {1'b0, job_r.piece[idx_r]} + CHAR_BIAS;
        run_end = end_char;
      end
      SEQ_CR: begin
        out_data.out_char = CHAR_CR;
      end
      SEQ_LF: begin
        out_data.out_char = CHAR_LF;
        run_end = (idx_r == job_r.last_idx);
      end
      default: begin
        out_data.out_char = CHAR_BIAS;
      end
    endcase
    out_data.run_end     = run_end;
    out_data.message_end = run_end && job_r.last;
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    st_nxt   = st_r;
    if (fire) begin
      case (st_r)
        SEQ_CHAR: begin
          if (at_brk) begin
            st_nxt = SEQ_CR;
          end else if (end_char) begin
            busy_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        SEQ_CR: begin
          st_nxt = SEQ_LF;
        end
        SEQ_LF: begin
          st_nxt = SEQ_CHAR;
          if (idx_r == job_r.last_idx) begin
            busy_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        default: begin
          st_nxt = SEQ_CHAR;
        end
      endcase
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
      st_nxt   = SEQ_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      st_r   <= SEQ_CHAR;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

endmodule

// File: design/sextet_text_encoder.sv
// Sextet text encoder: gathers bytes in threes and emits biased 6-bit characters.
// Latency: a group-closing beat shows its first character the cycle after acceptance.
// Throughput: one character per cycle if out_ready; a byte that only joins the group
// is taken in any cycle, a group-closing byte waits until the previous group drains.
// Output port sets the rate: four chars per three-byte group, two more per line break.
// Synchronous reset: wrap_lines set, group and column cleared, output idle.
module sextet_text_encoder #(
  parameter int LINE_CHARS = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ste_pkg::ste_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ste_pkg::ste_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import ste_pkg::*;

  localparam logic [7:0] LINE_W  = 8'(LINE_CHARS);
  localparam logic [7:0] LINE_M1 = 8'(LINE_CHARS - 1);

  logic       wrap_r;
  logic [1:0] fill_r, fill_nxt;
  logic [7:0] held0_r, held1_r;
  logic [6:0] col_r, col_nxt;

  logic       hold_item, accept, load, free;
  logic [7:0] s0, s1, s2, col_sum, brk_gap;
  ste_job_t   job;

  assign hold_item = !in_data.final_byte && (fill_r != 2'd2);
  assign in_ready  = hold_item || free;
  assign accept    = in_valid && in_ready;
  assign load      = accept && !hold_item;

  always_comb begin
    s0 = (fill_r == 2'd0) ? in_data.data_byte : held0_r;
    s1 = (fill_r == 2'd0) ? 8'd0 : ((fill_r == 2'd1) ? in_data.data_byte : held1_r);
    s2 = (fill_r == 2'd2) ? in_data.data_byte : 8'd0;

    job.piece[0] = s0[7:2];
    job.piece[1] = {s0[1:0], s1[7:4]};
    job.piece[2] = {s1[3:0], s2[7:6]};
    job.piece[3] = s2[5:0];
    job.last_idx = fill_r + 2'd1;
    job.last     = in_data.final_byte;

    // chars in group = fill + 2; at most one line break fits in a group
    col_sum = {1'b0, col_r} + {6'd0, fill_r} + 8'd2;
    brk_gap = LINE_M1 - {1'b0, col_r};
    job.brk     = wrap_r && !in_data.final_byte && (col_sum >= LINE_W);
    job.brk_pos = brk_gap[1:0];

    if (in_data.final_byte) begin
      col_nxt = 7'd0;
    end else if (!wrap_r) begin
      col_nxt = col_r;
    end else if (job.brk) begin
      col_nxt = 7'(col_sum - LINE_W);
    end else begin
      col_nxt = col_sum[6:0];
    end

    fill_nxt = hold_item ? (fill_r + 2'd1) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b1;
      fill_r <= 2'd0;
      col_r  <= 7'd0;
    end else begin
      if (cfg_we) begin
        wrap_r <= cfg_wdata;
      end
      if (accept) begin
        fill_r <= fill_nxt;
        if (!hold_item) begin
          col_r <= col_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_item) begin
      if (fill_r == 2'd0) begin
        held0_r <= in_data.data_byte;
      end else begin
        held1_r <= in_data.data_byte;
      end
    end
  end

  ste_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .job       (job),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
